// ===== hdl/ued_pkg.sv =====
package ued_pkg;

  // One character: bytes in bits 31..0, byte count in bits 34..32
  typedef logic [34:0] char_t;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_CAND  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [5:0] MATCH_LIMIT_RESET = 6'd3;
  localparam logic [5:0] DIST_MAX          = 6'd63;

  // Work handed from the byte front end to the column engine, applied in field order
  typedef struct packed {
    logic  new_query;
    logic  q_store;
    logic  cand_clear;
    logic  c_char;
    logic  emit;
    char_t q_char;
    char_t c_val;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_EMIT
  } back_state_e;

endpackage

// ===== hdl/ued_fifo.sv =====
module ued_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/ued_front.sv =====
module ued_front import ued_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] byte_req_i,
  input  logic       last_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [3:0] LEAD2_LO = 4'hC;
  localparam logic [3:0] LEAD2_HI = 4'hD;
  localparam logic [3:0] LEAD3    = 4'hE;
  localparam logic [3:0] LEAD4    = 4'hF;

  // Continuation bytes expected after a lead byte
  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] n;
    unique case (b[7:4]) inside
      LEAD2_LO, LEAD2_HI: n = 2'd1;
      LEAD3:              n = 2'd2;
      LEAD4:              n = 2'd3;
      default:            n = 2'd0;
    endcase
    return n;
  endfunction

  char_t      asm_q, asm_d;
  logic [1:0] left_q, left_d;
  logic       qc_q, qc_d;
  logic       accept, is_cand, restart, fin;
  logic [1:0] eff_left, new_left;
  char_t      new_asm;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_cand    = (mode_i == MODE_CAND);
  // a switch drops a partial candidate character but stores a query one
  assign restart    = is_cand ? !qc_q : qc_q;
  assign eff_left   = restart ? 2'd0 : left_q;

  always_comb begin
    if (eff_left == 2'd0) begin
      new_asm  = {3'd1, 24'd0, byte_req_i};
      new_left = lead_extra(byte_req_i);
    end else begin
      new_asm  = {asm_q[34:32] + 3'd1, asm_q[23:0], byte_req_i};
      new_left = eff_left - 2'd1;
    end
    fin = (new_left == 2'd0) || last_i;

    cmd_o.new_query  = !is_cand && qc_q;
    cmd_o.q_store    = is_cand ? (!qc_q && (left_q != 2'd0)) : fin;
    cmd_o.q_char     = is_cand ? asm_q : new_asm;
    cmd_o.cand_clear = is_cand ? !qc_q : qc_q;
    cmd_o.c_char     = is_cand && fin;
    cmd_o.c_val      = new_asm;
    cmd_o.emit       = is_cand && last_i;

    push_o = accept && (cmd_o.new_query || cmd_o.q_store || cmd_o.cand_clear ||
                        cmd_o.c_char || cmd_o.emit);

    asm_d  = asm_q;
    left_d = left_q;
    qc_d   = qc_q;
    if (accept) begin
      asm_d  = new_asm;
      left_d = fin ? 2'd0 : new_left;
      qc_d   = is_cand ? 1'b1 : last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q  <= '0;
      left_q <= '0;
      qc_q   <= 1'b0;
    end else begin
      asm_q  <= asm_d;
      left_q <= left_d;
      qc_q   <= qc_d;
    end
  end

endmodule

// ===== hdl/ued_back.sv =====
module ued_back import ued_pkg::*; #(
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  input  logic [5:0] match_limit_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] distance_o,
  output logic       close_match_o,
  output logic       truncated_o
);

  localparam int unsigned QAW = $clog2(MAX_CHARS);
  localparam int unsigned IW  = $clog2(MAX_CHARS + 1);
  localparam logic [IW-1:0] MAX_V = IW'(MAX_CHARS);

  char_t         qmem [MAX_CHARS];
  logic [IW-1:0] dpmem [MAX_CHARS + 1];

  back_state_e   state_q, state_d;
  logic [IW-1:0] qlen_q, qlen_d;
  logic          ovf_q, ovf_d;
  logic          fresh_q, fresh_d;
  logic [IW-1:0] clen_q, clen_d;
  logic          ctrunc_q, ctrunc_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] diag_q, diag_d;
  logic [IW-1:0] left_q, left_d;
  logic [IW-1:0] fin_q, fin_d;
  char_t         char_q, char_d;
  logic          emit_q, emit_d;
  logic          ovalid_q, ovalid_d;
  logic [5:0]    dist_q, dist_d;
  logic          close_q, close_d;
  logic          trunc_q, trunc_d;

  logic          q_we, q_re, dp_we, dp_re;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [IW-1:0] dp_waddr, dp_raddr, dp_wdata;
  char_t         q_rd_q;
  logic [IW-1:0] dp_rd_q;

  logic [IW-1:0] qbase, clen_eff, old_v, min_v, new_v, dval;
  logic [15:0]   d_ext;
  logic [5:0]    dist_v;
  logic          slot_free;

  assign slot_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    qlen_d   = qlen_q;
    ovf_d    = ovf_q;
    fresh_d  = fresh_q;
    clen_d   = clen_q;
    ctrunc_d = ctrunc_q;
    idx_d    = idx_q;
    diag_d   = diag_q;
    left_d   = left_q;
    fin_d    = fin_q;
    char_d   = char_q;
    emit_d   = emit_q;
    ovalid_d = slot_free ? 1'b0 : ovalid_q;
    dist_d   = dist_q;
    close_d  = close_q;
    trunc_d  = trunc_q;
    pop_o    = 1'b0;
    q_we     = 1'b0;
    q_waddr  = '0;
    q_re     = 1'b0;
    q_raddr  = idx_q[QAW-1:0];
    dp_we    = 1'b0;
    dp_waddr = idx_q;
    dp_wdata = '0;
    dp_re    = 1'b0;
    dp_raddr = '0;
    qbase    = cmd_i.new_query ? '0 : qlen_q;
    clen_eff = cmd_i.cand_clear ? '0 : clen_q;
    old_v    = fresh_q ? idx_q : dp_rd_q;
    min_v    = left_q;
    if (old_v < min_v) begin
      min_v = old_v;
    end
    if (diag_q < min_v) begin
      min_v = diag_q;
    end
    new_v    = (idx_q == '0) ? clen_q + IW'(1) :
               ((q_rd_q == char_q) ? diag_q : min_v + IW'(1));
    dval     = fresh_q ? qlen_q : fin_q;
    d_ext    = 16'(dval);
    dist_v   = (d_ext > 16'(DIST_MAX)) ? DIST_MAX : d_ext[5:0];

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.new_query) begin
            qlen_d = '0;
            ovf_d  = 1'b0;
          end
          if (cmd_i.q_store) begin
            if (qbase >= MAX_V) begin
              ovf_d = 1'b1;
            end else begin
              q_we    = 1'b1;
              q_waddr = qbase[QAW-1:0];
              qlen_d  = qbase + IW'(1);
            end
          end
          if (cmd_i.cand_clear) begin
            fresh_d  = 1'b1;
            clen_d   = '0;
            ctrunc_d = 1'b0;
          end
          char_d = cmd_i.c_val;
          emit_d = cmd_i.emit;
          if (cmd_i.c_char && (clen_eff < MAX_V)) begin
            // fetch row 0 so the sweep starts with it in hand
            dp_re    = 1'b1;
            dp_raddr = '0;
            idx_d    = '0;
            state_d  = S_SWEEP;
          end else begin
            if (cmd_i.c_char) begin
              ctrunc_d = 1'b1;
            end
            state_d = cmd_i.emit ? S_EMIT : S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        dp_we    = 1'b1;
        dp_wdata = new_v;
        diag_d   = old_v;
        left_d   = new_v;
        if (idx_q == qlen_q) begin
          fin_d   = new_v;
          fresh_d = 1'b0;
          clen_d  = clen_q + IW'(1);
          state_d = emit_q ? S_EMIT : S_IDLE;
        end else begin
          // read ahead: next row of the column and the query character it meets
          dp_re    = 1'b1;
          dp_raddr = idx_q + IW'(1);
          q_re     = 1'b1;
          idx_d    = idx_q + IW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          dist_d   = dist_v;
          close_d  = (dist_v < match_limit_i);
          trunc_d  = ovf_q || ctrunc_q;
          fresh_d  = 1'b1;
          clen_d   = '0;
          ctrunc_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      qlen_q   <= '0;
      ovf_q    <= 1'b0;
      fresh_q  <= 1'b1;
      clen_q   <= '0;
      ctrunc_q <= 1'b0;
      idx_q    <= '0;
      emit_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      qlen_q   <= qlen_d;
      ovf_q    <= ovf_d;
      fresh_q  <= fresh_d;
      clen_q   <= clen_d;
      ctrunc_q <= ctrunc_d;
      idx_q    <= idx_d;
      emit_q   <= emit_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q  <= diag_d;
    left_q  <= left_d;
    fin_q   <= fin_d;
    char_q  <= char_d;
    dist_q  <= dist_d;
    close_q <= close_d;
    trunc_q <= trunc_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= cmd_i.q_char;
    end
    if (q_re) begin
      q_rd_q <= qmem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_we) begin
      dpmem[dp_waddr] <= dp_wdata;
    end
    if (dp_re) begin
      dp_rd_q <= dpmem[dp_raddr];
    end
  end

  assign out_valid_o   = ovalid_q;
  assign distance_o    = dist_q;
  assign close_match_o = close_q;
  assign truncated_o   = trunc_q;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (idx_q <= qlen_q))
    else $error("sweep index beyond query length");

  a_cand_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (clen_q < MAX_V))
    else $error("sweep started on a full candidate");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && idx_q != qlen_q) |=>
      (state_q == S_SWEEP && idx_q == $past(idx_q) + IW'(1)))
    else $error("sweep did not advance one row");

  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= MAX_V)
    else $error("query length overflow");
`endif

endmodule

// ===== hdl/utf8_edit_distance.sv =====
// utf8_edit_distance: Levenshtein distance over UTF-8 characters.
// Input channel (in_valid_i / in_stall_o): one byte per item with mode_i
// (0 query, 1 candidate) and last_i marking the final byte of a string.
// Output channel (out_valid_o / out_stall_i): one item per candidate,
// issued after its last byte: distance_o, close_match_o, truncated_o.
// Configuration: cfg_we_i writes cfg_wdata_i into match_limit (reset 3);
// write only while the block is idle.
// Bytes enter at one per cycle into a two-entry command queue; the front
// stalls only when that queue is full. Each completed candidate character
// costs the column engine a pop that fetches row 0, then one row of the
// distance column per cycle, reading the next row while writing the current
// one. A stored query character or the start of a candidate takes a single
// pop in the idle state; other bytes inside a character never reach the
// engine.
// After the last row is written, the engine passes through its emit state,
// where the output register takes the result once it is free.
// A finished result waits in the output register while the receiver
// stalls; the engine holds only with a second result ready, the queue keeps filling.
// Reset clears all control state and the stored query length; no memory
// clearing pass is needed.
module utf8_edit_distance import ued_pkg::*; #(
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] byte_req_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] distance_o,
  output logic       close_match_o,
  output logic       truncated_o,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);

  localparam int unsigned CMD_W = $bits(cmd_t);

  logic [5:0] match_limit_q;
  logic       push, pop, full, empty;
  cmd_t       cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_limit_q <= MATCH_LIMIT_RESET;
    end else if (cfg_we_i) begin
      match_limit_q <= cfg_wdata_i;
    end
  end

  ued_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .byte_req_i (byte_req_i),
    .last_i     (last_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  ued_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (cmd_out),
    .empty_o (empty),
    .full_o  (full)
  );

  ued_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .match_limit_i (match_limit_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .distance_o    (distance_o),
    .close_match_o (close_match_o),
    .truncated_o   (truncated_o)
  );

endmodule

// ===== tb/sv/ued_checker.sv =====
`timescale 1ns / 1ps

module ued_checker import ued_pkg::*; #(
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       mode_i,
  input  logic [7:0] byte_req_i,
  input  logic       last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [5:0] distance_i,
  input  logic       close_match_i,
  input  logic       truncated_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  typedef struct packed {
    logic [5:0] distance;
    logic       close_match;
    logic       truncated;
  } dist_item_t;

  char_t       query_mem [MAX_CHARS];
  int unsigned query_len;
  int unsigned dist_col [MAX_CHARS + 1];
  char_t       char_acc;
  int unsigned pend_bytes;
  int unsigned cand_len;
  logic        query_done;
  logic        query_trunc;
  logic        cand_trunc;
  logic [5:0]  limit;
  dist_item_t  dist_exp_q [$];
  int          fails = 0;
  int          waiting = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = waiting;

  function automatic int unsigned seq_len(logic [7:0] b);
    if (!b[7]) return 1;
    case (b[7:4])
      4'hC, 4'hD: return 2;
      4'hE: return 3;
      4'hF: return 4;
      default: return 1;
    endcase
  endfunction

  // Returns 1 once the character in char_acc is complete
  function automatic logic add_byte(logic [7:0] b);
    if (pend_bytes == 0) begin
      char_acc   = {3'd1, 24'd0, b};
      pend_bytes = seq_len(b) - 1;
    end else begin
      char_acc = {char_acc[34:32] + 3'd1, char_acc[23:0], b};
      pend_bytes--;
    end
    return pend_bytes == 0;
  endfunction

  function automatic void store_query_char();
    if (query_len >= MAX_CHARS) begin
      query_trunc = 1'b1;
    end else begin
      query_mem[query_len] = char_acc;
      query_len++;
    end
    char_acc   = '0;
    pend_bytes = 0;
  endfunction

  // Advance the distance column by one candidate character
  function automatic void fold_cand_char();
    int unsigned diag;
    int unsigned prev;
    int unsigned best;
    int unsigned i;
    if (cand_len >= MAX_CHARS) begin
      cand_trunc = 1'b1;
    end else begin
      diag = dist_col[0];
      dist_col[0] = cand_len + 1;
      for (i = 1; i <= query_len; i++) begin
        prev = dist_col[i];
        if (query_mem[i - 1] == char_acc) begin
          dist_col[i] = diag;
        end else begin
          best = dist_col[i - 1];
          if (prev < best) best = prev;
          if (diag < best) best = diag;
          dist_col[i] = best + 1;
        end
        diag = prev;
      end
      cand_len++;
    end
    char_acc   = '0;
    pend_bytes = 0;
  endfunction

  function automatic void clear_cand();
    int unsigned i;
    for (i = 0; i <= MAX_CHARS; i++) dist_col[i] = i;
    cand_len   = 0;
    cand_trunc = 1'b0;
    char_acc   = '0;
    pend_bytes = 0;
  endfunction

  function automatic void reset_state();
    query_len   = 0;
    query_done  = 1'b0;
    query_trunc = 1'b0;
    limit       = MATCH_LIMIT_RESET;
    clear_cand();
    dist_exp_q.delete();
  endfunction

  function automatic void take_item(logic m, logic [7:0] b, logic l);
    logic        done;
    int unsigned d;
    dist_item_t  r;
    if (m == MODE_QUERY) begin
      // a query byte after a finished query starts a new one
      if (query_done) begin
        query_len   = 0;
        query_trunc = 1'b0;
        query_done  = 1'b0;
        clear_cand();
      end
      done = add_byte(b);
      if (done || l) store_query_char();
      if (l) query_done = 1'b1;
    end else begin
      // a candidate byte closes an unfinished query, keeping a partial character
      if (!query_done) begin
        if (pend_bytes != 0) store_query_char();
        query_done = 1'b1;
        clear_cand();
      end
      done = add_byte(b);
      if (done || l) fold_cand_char();
      if (l) begin
        d = dist_col[query_len];
        if (d > DIST_MAX) d = DIST_MAX;
        r.distance    = 6'(d);
        r.close_match = r.distance < limit;
        r.truncated   = query_trunc || cand_trunc;
        dist_exp_q.push_back(r);
        clear_cand();
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : mon
    dist_item_t want;
    if (!rst_ni) begin
      reset_state();
    end else begin
      // results leave before this edge's input can produce one
      if (out_valid_i && !out_stall_i) begin
        if (dist_exp_q.size() == 0) begin
          $error("unexpected distance item: distance %0d", distance_i);
          fails++;
        end else begin
          want = dist_exp_q.pop_front();
          if (distance_i !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, distance_i);
            fails++;
          end
          if (close_match_i !== want.close_match) begin
            $error("close_match: expected %0d, got %0d", want.close_match, close_match_i);
            fails++;
          end
          if (truncated_i !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, truncated_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) take_item(mode_i, byte_req_i, last_i);
    end
    waiting = dist_exp_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import ued_pkg::*; ();

  localparam int unsigned PHASE_ITEMS   = 345;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned END_WAIT      = 100000;
  localparam longint      RUN_LIMIT_NS  = 64'd20_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = MODE_QUERY;
  logic [7:0] byte_req = 8'd0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] distance;
  logic       close_match;
  logic       truncated;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;

  int          fails;
  int          pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;
  int unsigned items_sent = 0;

  logic [7:0] str_q [$];
  char_t      qry_chars [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utf8_edit_distance u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .byte_req_i    (byte_req),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .distance_o    (distance),
    .close_match_o (close_match),
    .truncated_o   (truncated),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  ued_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .mode_i        (mode),
    .byte_req_i    (byte_req),
    .last_i        (last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .distance_i    (distance),
    .close_match_i (close_match),
    .truncated_i   (truncated),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .fail_cnt_o    (fails),
    .pending_o     (pending)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cnt  = LONG_HOLD;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Entered and left at a falling edge; valid stays high for a following item
  task automatic put_byte(logic m, logic [7:0] b, logic l);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    byte_req <= b;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(logic [5:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic char_t pick_char();
    int unsigned n;
    logic [7:0]  lead;
    logic [31:0] word;
    case ($urandom_range(0, 9))
      0, 1, 2: return {3'd1, 24'd0, 8'h61 + 8'($urandom_range(0, 2))};
      3: return {3'd2, 16'd0, 8'hC3, 8'hA0 + 8'($urandom_range(0, 1))};
      4: return {3'd3, 8'd0, 24'hE282AC};
      5: return {3'd4, 24'hF09F98, 8'h80 + 8'($urandom_range(0, 1))};
      6: return {3'd1, 24'd0, 2'b10, 6'($urandom)};
      default: begin
        n = $urandom_range(1, 4);
        case (n)
          1: lead = {1'b0, 7'($urandom)};
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          default: lead = {4'b1111, 4'($urandom)};
        endcase
        word = 32'($urandom);
        if (n < 4) word = word & ((32'd1 << (8 * n)) - 32'd1);
        word[8 * n - 1 -: 8] = lead;
        return {3'(n), word};
      end
    endcase
  endfunction

  function automatic void push_char(char_t c);
    int k;
    for (k = int'(c[34:32]) - 1; k >= 0; k--) str_q.push_back(c[8 * k +: 8]);
  endfunction

  task automatic send_str(logic m, logic with_last);
    int n;
    int i;
    n = str_q.size();
    for (i = 0; i < n; i++) put_byte(m, str_q[i], with_last && (i == n - 1));
    str_q.delete();
  endtask

  task automatic send_query();
    int unsigned n;
    int unsigned i;
    char_t       c;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
    qry_chars.delete();
    for (i = 0; i < n; i++) begin
      c = pick_char();
      qry_chars.push_back(c);
      push_char(c);
    end
    case ($urandom_range(0, 9))
      // no last byte: the candidate ends the query
      0: send_str(MODE_QUERY, 1'b0);
      // may end inside a character
      1: begin
        if (str_q.size() > 1) void'(str_q.pop_back());
        send_str(MODE_QUERY, 1'b1);
      end
      default: send_str(MODE_QUERY, 1'b1);
    endcase
  endtask

  task automatic send_cand();
    int unsigned n;
    int unsigned i;
    if ($urandom_range(0, 14) == 0) begin
      n = $urandom_range(33, 36);
      for (i = 0; i < n; i++) push_char(pick_char());
    end else begin
      // mutate the query: substitute, drop, insert, keep
      foreach (qry_chars[j]) begin
        case ($urandom_range(0, 9))
          0: push_char(pick_char());
          1: ;
          2: begin
            push_char(pick_char());
            push_char(qry_chars[j]);
          end
          default: push_char(qry_chars[j]);
        endcase
      end
      if ($urandom_range(0, 3) == 0) push_char(pick_char());
    end
    if (str_q.size() == 0) push_char(pick_char());
    if ($urandom_range(0, 11) == 0) begin
      if (str_q.size() > 1) void'(str_q.pop_back());
      send_str(MODE_CAND, 1'($urandom_range(0, 1)));
    end else begin
      send_str(MODE_CAND, 1'b1);
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      put_byte(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned first;
    logic        paused;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent - first < n_items) begin
      // hold the sender once until every result is in
      if (!paused && (items_sent - first >= n_items / 2)) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_query();
        repeat ($urandom_range(1, 4)) send_cand();
      end
    end
  endtask

  initial begin : stim
    int unsigned w;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // candidate against an empty query
    put_byte(MODE_CAND, 8'h61, 1'b0);
    put_byte(MODE_CAND, 8'h62, 1'b1);
    // query with NUL, every character length and a stray continuation byte
    put_byte(MODE_QUERY, 8'h00, 1'b0);
    put_byte(MODE_QUERY, 8'hC3, 1'b0);
    put_byte(MODE_QUERY, 8'hA9, 1'b0);
    put_byte(MODE_QUERY, 8'hE2, 1'b0);
    put_byte(MODE_QUERY, 8'h82, 1'b0);
    put_byte(MODE_QUERY, 8'hAC, 1'b0);
    put_byte(MODE_QUERY, 8'hF0, 1'b0);
    put_byte(MODE_QUERY, 8'h9F, 1'b0);
    put_byte(MODE_QUERY, 8'h98, 1'b0);
    put_byte(MODE_QUERY, 8'h80, 1'b0);
    put_byte(MODE_QUERY, 8'h80, 1'b0);
    put_byte(MODE_QUERY, 8'h7F, 1'b1);
    // candidate ending inside a four-byte character
    put_byte(MODE_CAND, 8'hFF, 1'b1);
    // candidate arrives before the query's last byte, mid-character
    put_byte(MODE_QUERY, 8'h41, 1'b0);
    put_byte(MODE_QUERY, 8'hE2, 1'b0);
    put_byte(MODE_CAND, 8'h41, 1'b1);
    // unfinished candidate abandoned by a new query
    put_byte(MODE_CAND, 8'h42, 1'b0);
    put_byte(MODE_QUERY, 8'h42, 1'b1);
    put_byte(MODE_CAND, 8'h42, 1'b1);

    // no idling, long receiver hold-off at the start
    set_limit(6'd0);
    hold_reqs++;
    run_phase(PHASE_ITEMS);

    set_limit(6'd33);
    idle_pct  = 82;
    stall_pct = 0;
    run_phase(PHASE_ITEMS);

    set_limit(6'($urandom_range(2, 12)));
    idle_pct  = 0;
    stall_pct = 82;
    run_phase(PHASE_ITEMS);

    set_limit(6'd30);
    idle_pct  = 28;
    stall_pct = 28;
    run_phase(PHASE_ITEMS);

    in_valid <= 1'b0;
    for (w = 0; w < END_WAIT && pending != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) $error("%0d distance items never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
